@@ rtl/rtwe_pkg.sv @@
`timescale 1ns / 1ps

package rtwe_pkg;

    localparam int TIME_W  = 32;
    localparam int LOAD_W  = 24;
    localparam int DEM_W   = 16;
    localparam int CAP_W   = 16;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 32;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [LOAD_W-1:0]  load_t;
    typedef logic [CIDX_W-1:0]  cfg_idx_t;
    typedef logic [CDATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_VEHICLE_CAPACITY = cfg_idx_t'(0);
    localparam cfg_idx_t REG_DEPOT_CLOSE_TIME = cfg_idx_t'(1);

    typedef struct packed {
        time_t             leg_distance;
        time_t             return_distance;
        logic [DEM_W-1:0]  demand;
        time_t             window_open;
        time_t             window_close;
        time_t             service_time;
        logic              last_visit;
    } visit_t;

    typedef struct packed {
        time_t total_distance;
        time_t total_timewarp;
        time_t total_waiting;
        load_t total_load;
        logic  route_feasible;
    } result_t;

    function automatic time_t sat_add(time_t a, time_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

@@ rtl/rtwe_if.sv @@
`timescale 1ns / 1ps

interface rtwe_visit_if;
    logic                valid;
    logic                ready;
    rtwe_pkg::visit_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtwe_result_if;
    logic                valid;
    logic                ready;
    rtwe_pkg::result_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtwe_cfg_if;
    logic                valid;
    logic                ready;
    rtwe_pkg::cfg_idx_t  index;
    rtwe_pkg::cfg_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/route_time_window_evaluator.sv @@
`timescale 1ns / 1ps
// Route time-window evaluator.
// visit  : sink channel, one customer visit per transfer; last_visit ends a route.
// result : source channel, one transfer per route with distance, time warp,
//          waiting, load totals and a feasibility flag.
// cfg    : register write channel, always ready; index 0 vehicle_capacity,
//          index 1 depot_close_time. Write only while no route is in flight.
// A visit is captured in an input register, then applied to the route
// accumulators when it leaves that register; a route total is loaded into the
// result register as its last visit leaves the input register. One visit per
// cycle is sustained while no last visit waits on a full result register:
// the adder/compare chain of one visit sits between the input register and
// the accumulators and the result register.
// When result is stalled, visits that are not last keep flowing; a last visit
// waits in the input register until the result register frees, and visit
// ready drops only then.
// Reset clears the accumulators (feasible set), the config registers and all valids.
module route_time_window_evaluator (
    input  logic                  clk,
    input  logic                  rst_n,
    rtwe_visit_if.sink            visit,
    rtwe_result_if.source         result,
    rtwe_cfg_if.sink              cfg
);

    logic [rtwe_pkg::CAP_W-1:0] capacity_reg;
    rtwe_pkg::time_t            depot_close_reg;

    logic                       s1_valid_reg;
    rtwe_pkg::visit_t           s1_data_reg;

    rtwe_pkg::time_t            clock_reg, clock_next;
    rtwe_pkg::time_t            dist_reg, dist_next;
    rtwe_pkg::time_t            late_reg, late_next;
    rtwe_pkg::time_t            wait_reg, wait_next;
    rtwe_pkg::load_t            load_reg, load_next;
    logic                       feas_reg, feas_next;

    logic                       out_valid_reg;
    rtwe_pkg::result_t          out_reg;

    logic                       s1_adv;
    logic                       s1_emit;
    logic [rtwe_pkg::LOAD_W:0]  load_sum;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= '0;
            depot_close_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rtwe_pkg::REG_VEHICLE_CAPACITY: capacity_reg <= cfg.data[rtwe_pkg::CAP_W-1:0];
                rtwe_pkg::REG_DEPOT_CLOSE_TIME: depot_close_reg <= cfg.data[rtwe_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_emit     = s1_valid_reg && s1_data_reg.last_visit;
    assign s1_adv      = s1_valid_reg && (!s1_data_reg.last_visit || !out_valid_reg
                                          || result.ready);
    assign visit.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (visit.ready)
            s1_valid_reg <= visit.valid;
    end

    always_ff @(posedge clk)
    begin
        if (visit.ready && visit.valid)
            s1_data_reg <= visit.data;
    end

    always_comb
    begin
        rtwe_pkg::time_t clk_t;
        clk_t     = rtwe_pkg::sat_add(clock_reg, s1_data_reg.leg_distance);
        dist_next = rtwe_pkg::sat_add(dist_reg, s1_data_reg.leg_distance);
        late_next = late_reg;
        wait_next = wait_reg;
        feas_next = feas_reg;

        load_sum  = {1'b0, load_reg} + (rtwe_pkg::LOAD_W + 1)'(s1_data_reg.demand);
        load_next = load_sum[rtwe_pkg::LOAD_W] ? {rtwe_pkg::LOAD_W{1'b1}}
                                               : load_sum[rtwe_pkg::LOAD_W-1:0];
        if (load_next > rtwe_pkg::LOAD_W'(capacity_reg))
            feas_next = 1'b0;

        if (clk_t > s1_data_reg.window_close)
        begin
            feas_next = 1'b0;
            late_next = rtwe_pkg::sat_add(late_next, clk_t - s1_data_reg.window_close);
            clk_t     = s1_data_reg.window_close;
        end
        else if (clk_t < s1_data_reg.window_open)
        begin
            wait_next = rtwe_pkg::sat_add(wait_next, s1_data_reg.window_open - clk_t);
            clk_t     = s1_data_reg.window_open;
        end

        clk_t = rtwe_pkg::sat_add(clk_t, s1_data_reg.service_time);

        if (s1_data_reg.last_visit)
        begin
            clk_t     = rtwe_pkg::sat_add(clk_t, s1_data_reg.return_distance);
            dist_next = rtwe_pkg::sat_add(dist_next, s1_data_reg.return_distance);
            if (clk_t > depot_close_reg)
            begin
                feas_next = 1'b0;
                late_next = rtwe_pkg::sat_add(late_next, clk_t - depot_close_reg);
            end
        end
        clock_next = clk_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
            dist_reg  <= '0;
            late_reg  <= '0;
            wait_reg  <= '0;
            load_reg  <= '0;
            feas_reg  <= 1'b1;
        end
        else if (s1_adv)
        begin
            if (s1_data_reg.last_visit)
            begin
                clock_reg <= '0;
                dist_reg  <= '0;
                late_reg  <= '0;
                wait_reg  <= '0;
                load_reg  <= '0;
                feas_reg  <= 1'b1;
            end
            else
            begin
                clock_reg <= clock_next;
                dist_reg  <= dist_next;
                late_reg  <= late_next;
                wait_reg  <= wait_next;
                load_reg  <= load_next;
                feas_reg  <= feas_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit)
        begin
            out_reg.total_distance <= dist_next;
            out_reg.total_timewarp <= late_next;
            out_reg.total_waiting  <= wait_next;
            out_reg.total_load     <= load_next;
            out_reg.route_feasible <= feas_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // no lateness anywhere means no time warp
    a_feasible_no_warp: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.route_feasible) |-> (result.data.total_timewarp == '0))
        else $error("feasible route reports time warp");

    // a route end leaves the accumulators cleared
    a_route_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emit) |=> (clock_reg == '0 && dist_reg == '0 && late_reg == '0
                                 && wait_reg == '0 && load_reg == '0 && feas_reg))
        else $error("route state not cleared after last visit");

    // back-pressure only from a last visit held behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !visit.ready |-> (s1_emit && out_valid_reg && !result.ready))
        else $error("visit stalled without a blocked route end");

endmodule

@@ tb/sv/tb_route_time_window_evaluator.sv @@
`timescale 1ns / 1ps

module tb_route_time_window_evaluator;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_VISITS  = 110;
    localparam int HEAVY_VISITS  = 260;

    class route_tally;
        logic [rtwe_pkg::CAP_W-1:0] capacity;
        rtwe_pkg::time_t            depot_close;
        rtwe_pkg::time_t            clock_acc;
        rtwe_pkg::time_t            dist_acc;
        rtwe_pkg::time_t            late_acc;
        rtwe_pkg::time_t            wait_acc;
        rtwe_pkg::load_t            load_acc;
        logic                       feasible;
        rtwe_pkg::result_t          totals_q[$];
        int                         errors;

        function new();
            errors      = 0;
            capacity    = '0;
            depot_close = '0;
            clear_route();
        endfunction

        function void clear_route();
            clock_acc = '0;
            dist_acc  = '0;
            late_acc  = '0;
            wait_acc  = '0;
            load_acc  = '0;
            feasible  = 1'b1;
        endfunction

        function rtwe_pkg::time_t add_sat(rtwe_pkg::time_t a, rtwe_pkg::time_t b);
            logic [rtwe_pkg::TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s[rtwe_pkg::TIME_W])
                return {rtwe_pkg::TIME_W{1'b1}};
            return s[rtwe_pkg::TIME_W-1:0];
        endfunction

        function void set_register(rtwe_pkg::cfg_idx_t idx, rtwe_pkg::cfg_data_t d);
            if (idx == rtwe_pkg::REG_VEHICLE_CAPACITY)
                capacity = d[rtwe_pkg::CAP_W-1:0];
            else if (idx == rtwe_pkg::REG_DEPOT_CLOSE_TIME)
                depot_close = d[rtwe_pkg::TIME_W-1:0];
        endfunction

        function void apply_visit(rtwe_pkg::visit_t v);
            logic [rtwe_pkg::LOAD_W:0] l;
            rtwe_pkg::result_t         r;
            clock_acc = add_sat(clock_acc, v.leg_distance);
            dist_acc  = add_sat(dist_acc, v.leg_distance);
            l = {1'b0, load_acc} + (rtwe_pkg::LOAD_W + 1)'(v.demand);
            load_acc = l[rtwe_pkg::LOAD_W] ? {rtwe_pkg::LOAD_W{1'b1}}
                                           : l[rtwe_pkg::LOAD_W-1:0];
            if (load_acc > rtwe_pkg::LOAD_W'(capacity))
                feasible = 1'b0;
            if (clock_acc > v.window_close) begin
                feasible  = 1'b0;
                late_acc  = add_sat(late_acc, clock_acc - v.window_close);
                clock_acc = v.window_close;
            end
            else if (clock_acc < v.window_open) begin
                wait_acc  = add_sat(wait_acc, v.window_open - clock_acc);
                clock_acc = v.window_open;
            end
            clock_acc = add_sat(clock_acc, v.service_time);
            if (v.last_visit) begin
                clock_acc = add_sat(clock_acc, v.return_distance);
                dist_acc  = add_sat(dist_acc, v.return_distance);
                if (clock_acc > depot_close) begin
                    feasible = 1'b0;
                    late_acc = add_sat(late_acc, clock_acc - depot_close);
                end
                r.total_distance = dist_acc;
                r.total_timewarp = late_acc;
                r.total_waiting  = wait_acc;
                r.total_load     = load_acc;
                r.route_feasible = feasible;
                totals_q.push_back(r);
                clear_route();
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_totals(rtwe_pkg::result_t act);
            rtwe_pkg::result_t exp_r;
            if (totals_q.size() == 0) begin
                $display("%0t: route result with no route pending, expected none, got %h",
                         $time, act);
                errors++;
                return;
            end
            exp_r = totals_q.pop_front();
            compare_field("total_distance", exp_r.total_distance, act.total_distance);
            compare_field("total_timewarp", exp_r.total_timewarp, act.total_timewarp);
            compare_field("total_waiting", exp_r.total_waiting, act.total_waiting);
            compare_field("total_load", 32'(exp_r.total_load), 32'(act.total_load));
            compare_field("route_feasible", 32'(exp_r.route_feasible), 32'(act.route_feasible));
        endfunction

        function int outstanding();
            return totals_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rtwe_visit_if  visit_ch();
    rtwe_result_if result_ch();
    rtwe_cfg_if    cfg_ch();

    route_tally tally = new();
    bit         hold_off;
    int         burst_left;
    int         cycle_count;
    int         sent;

    route_time_window_evaluator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .visit  (visit_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && visit_ch.valid && visit_ch.ready)
            tally.apply_visit(visit_ch.data);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tally.check_totals(result_ch.data);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // receiver: ready pattern changes per segment; one long hold-off on request
    initial
    begin
        int mode;
        int seg_left;
        mode = 0;
        seg_left = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    default: result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 30);
        return $urandom_range(1, 5);
    endfunction

    task automatic send_visit(rtwe_pkg::visit_t v);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0) begin
            visit_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        visit_ch.data  <= v;
        visit_ch.valid <= 1'b1;
        @(posedge clk);
        while (!visit_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(rtwe_pkg::cfg_idx_t idx, rtwe_pkg::cfg_data_t d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        tally.set_register(idx, d);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_limits(logic [rtwe_pkg::CAP_W-1:0] cap, rtwe_pkg::time_t depot);
        write_reg(rtwe_pkg::REG_VEHICLE_CAPACITY, rtwe_pkg::cfg_data_t'(cap));
        write_reg(rtwe_pkg::REG_DEPOT_CLOSE_TIME, rtwe_pkg::cfg_data_t'(depot));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        visit_ch.valid <= 1'b0;
        while (tally.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic rtwe_pkg::visit_t make_visit(rtwe_pkg::time_t leg,
                                                    rtwe_pkg::time_t ret,
                                                    logic [rtwe_pkg::DEM_W-1:0] dem,
                                                    rtwe_pkg::time_t wo,
                                                    rtwe_pkg::time_t wc,
                                                    rtwe_pkg::time_t svc, logic last);
        rtwe_pkg::visit_t v;
        v.leg_distance    = leg;
        v.return_distance = ret;
        v.demand          = dem;
        v.window_open     = wo;
        v.window_close    = wc;
        v.service_time    = svc;
        v.last_visit      = last;
        return v;
    endfunction

    function automatic rtwe_pkg::time_t pick_time(int span);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            default: return $urandom_range(0, span);
        endcase
    endfunction

    function automatic rtwe_pkg::visit_t rand_visit(logic last);
        rtwe_pkg::visit_t v;
        v.leg_distance    = pick_time(1200);
        v.return_distance = pick_time(1200);
        v.service_time    = pick_time(400);
        case ($urandom_range(0, 5))
            0:       v.demand = rtwe_pkg::DEM_W'($urandom());
            1:       v.demand = '1;
            2:       v.demand = '0;
            default: v.demand = rtwe_pkg::DEM_W'($urandom_range(0, 60));
        endcase
        v.window_open = pick_time(6000);
        case ($urandom_range(0, 9))
            0:       v.window_close = $urandom();
            1:       v.window_close = v.window_open - $urandom_range(0, 3000);
            2:       v.window_close = '1;
            default: v.window_close = v.window_open + $urandom_range(0, 4000);
        endcase
        v.last_visit = last;
        return v;
    endfunction

    task automatic run_route(int len, bit heavy);
        rtwe_pkg::visit_t v;
        for (int i = 0; i < len; i++)
        begin
            v = rand_visit(i == len - 1);
            if (heavy)
                v.demand = '1;
            send_visit(v);
        end
    endtask

    initial
    begin
        int phase_start;
        int len;
        rst_n           = 1'b0;
        hold_off        = 1'b0;
        burst_left      = 0;
        sent            = 0;
        visit_ch.valid  = 1'b0;
        visit_ch.data   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_limits(16'd100, 32'h0010_0000);
        send_visit(make_visit(100, 50, 16'd10, 500, 1000, 20, 1'b1));
        send_visit(make_visit(0, 0, 16'd0, 0, 0, 0, 1'b1));
        // late, inverted window early, inverted window late, overload
        send_visit(make_visit(2000, 0, 16'd30, 0, 1000, 10, 1'b0));
        send_visit(make_visit(10, 0, 16'd30, 2000, 1500, 5, 1'b0));
        send_visit(make_visit(600, 0, 16'd50, 3000, 1000, 0, 1'b0));
        send_visit(make_visit(5, 7, 16'd0, 0, '1, 0, 1'b1));
        // saturated clock and distance, depot lateness from the saturated clock
        send_visit(make_visit('1, 0, 16'd0, 0, '1, '1, 1'b0));
        send_visit(make_visit('1, '1, '1, '1, '1, '1, 1'b1));
        // lateness sum saturates
        send_visit(make_visit('1, 0, 16'd0, 0, 100, 0, 1'b0));
        send_visit(make_visit('1, 0, 16'd0, 0, 0, 0, 1'b0));
        send_visit(make_visit(0, '1, 16'd0, 0, '1, 0, 1'b1));
        send_visit(make_visit(1, 0, 16'd0, '1, '1, 0, 1'b1));
        wait_drained();

        set_limits(16'd0, 32'd0);
        send_visit(make_visit(0, 0, 16'd0, 0, 0, 0, 1'b1));
        send_visit(make_visit(1, 0, 16'd1, 0, 10, 0, 1'b1));
        send_visit(make_visit(0, 3, 16'd0, 8, 2, 0, 1'b1));
        wait_drained();

        set_limits('1, '1);
        send_visit(make_visit(0, 0, '1, 0, 0, 0, 1'b1));
        send_visit(make_visit(5, 5, 16'd100, 10, 5, 0, 1'b1));
        send_visit(make_visit(5, 0, 16'd1, 0, 5, 3, 1'b0));
        send_visit(make_visit(0, '1, 16'd1, 0, '1, 0, 1'b1));
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       set_limits('0, '0);
                1:       set_limits('1, '1);
                2:       set_limits(rtwe_pkg::CAP_W'($urandom_range(0, 400)),
                                    $urandom_range(0, 40000));
                3:       set_limits(rtwe_pkg::CAP_W'($urandom()), $urandom());
                default: set_limits('1, $urandom_range(0, 60000));
            endcase
            if (ph == 3)
                hold_off = 1'b1;
            if (ph == 4)
                run_route(HEAVY_VISITS, 1'b1);
            phase_start = sent;
            while (sent - phase_start < PHASE_VISITS)
            begin
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(7, 20);
                else
                    len = $urandom_range(1, 6);
                run_route(len, 1'b0);
            end
            wait_drained();
        end

        if (tally.errors == 0 && tally.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ route_time_window_evaluator.f @@
rtl/rtwe_pkg.sv
rtl/rtwe_if.sv
rtl/route_time_window_evaluator.sv
tb/sv/tb_route_time_window_evaluator.sv
